// ===== sv/aubs_pkg.sv =====
// ----------------------------------------------------------------------------
// aubs_pkg
// Types, widths and constants shared by the update budget scheduler.
// ----------------------------------------------------------------------------
package aubs_pkg;

  typedef logic [11:0] cnt_t;   // entry counts and indexes
  typedef logic [19:0] us_t;    // microseconds
  typedef logic [27:0] avg_t;   // microseconds, Q20.8
  typedef logic [3:0]  run_t;   // run lengths and run counters
  typedef logic [7:0]  step_t;  // grow / shrink amounts
  typedef logic [8:0]  wgt_t;   // Q1.8 weight, 256 is one

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_FLOOR     = 3'd0,
    REG_GROW      = 3'd1,
    REG_SHRINK    = 3'd2,
    REG_SUCC_RUN  = 3'd3,
    REG_FAIL_RUN  = 3'd4,
    REG_WEIGHT    = 3'd5,
    REG_TARGET    = 3'd6
  } reg_idx_t;

  localparam cnt_t  FLOOR_RST    = 12'd30;
  localparam step_t GROW_RST     = 8'd5;
  localparam step_t SHRINK_RST   = 8'd15;
  localparam run_t  SUCC_RUN_RST = 4'd4;
  localparam run_t  FAIL_RUN_RST = 4'd1;
  localparam wgt_t  WEIGHT_RST   = 9'd38;
  localparam us_t   TARGET_RST   = 20'd16600;

  localparam wgt_t  WEIGHT_ONE   = 9'd256;
  localparam avg_t  SEED_Q8      = 28'(8000 * 256);
  localparam avg_t  ROOMY_Q8     = 28'(1500 * 256);
  localparam avg_t  TIGHT_Q8     = 28'(500 * 256);
  localparam logic [37:0] ROUND_Q8 = 38'd128;

  typedef struct packed {
    cnt_t  floor_count;
    step_t grow_step;
    step_t shrink_step;
    run_t  success_run;
    run_t  failure_run;
    wgt_t  weight;
    us_t   target;
  } cfg_t;

  // service window for one frame
  typedef struct packed {
    cnt_t g;            // clamped guaranteed count
    cnt_t high;
    cnt_t pool;
    cnt_t rr;
    cnt_t start;
    cnt_t cursor_next;
  } win_t;

  // adaptation decision for one frame
  typedef struct packed {
    cnt_t g_next;
    avg_t avg_next;
    logic seen_next;
    run_t succ_next;
    run_t fail_next;
    cnt_t clr_from;
    cnt_t clr_to;
  } adapt_t;

endpackage

// ===== sv/adaptive_update_budget_scheduler.sv =====
// ----------------------------------------------------------------------------
// adaptive_update_budget_scheduler
// Per-frame service window and adaptive guaranteed count for a ranked list.
// ----------------------------------------------------------------------------
// One input word per frame (entry total, measured non-render time) gives one
// result word: the fixed head 0..high_count-1, a round-robin window of
// rotate_count entries from rotate_start wrapping at pool_size, the demoted
// range clear_from..clear_to-1 when the guaranteed count shrank, and the count
// that applies from the next frame. A word is taken every clock unless the
// output stalls: it lands in an input register, and as it moves on one pass
// of logic (window clamp, a 9x20 and a 9x28 multiply for the moving average,
// budget compare and hysteresis) writes the result register and the scheduler
// state together, so the next word already sees the updated state. While a
// result waits on a stalled output the input register takes one more word and
// then holds the input off. The user must write registers on the cfg port only
// while no word is in flight, not enforced by the block; index 7 is ignored.
// A total of zero returns skipped with empty ranges and leaves all state alone.
// ----------------------------------------------------------------------------
module adaptive_update_budget_scheduler #(
  parameter int unsigned MAX_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [11:0] total_entries, [31:12] other_time_us
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // [11:0] high_count, [23:12] rotate_start,
                                 // [35:24] rotate_count, [47:36] pool_size,
                                 // [59:48] clear_from, [71:60] clear_to,
                                 // [83:72] next_guaranteed, [87:84] zero
  output logic        m_tuser,   // [0] skipped
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int unsigned LIMIT = MAX_ENTRIES - 1;

  // configuration
  aubs_pkg::cfg_t cfg;

  // scheduler state
  aubs_pkg::cnt_t guaranteed_count;
  aubs_pkg::cnt_t rotate_cursor;
  aubs_pkg::run_t success_counter;
  aubs_pkg::run_t failure_counter;
  logic           time_seen;
  aubs_pkg::avg_t average_time;

  // input register
  logic           in_valid;
  aubs_pkg::cnt_t in_total;
  aubs_pkg::us_t  in_sample;

  // result register
  logic           out_valid;
  logic           out_skipped;
  aubs_pkg::cnt_t out_high, out_start, out_rr, out_pool, out_from, out_to, out_next_g;

  logic             advance;
  aubs_pkg::cnt_t   total;
  logic             zero_total;
  aubs_pkg::win_t   win;
  aubs_pkg::adapt_t adapt;

  // input stage moves on whenever the result register is free or draining
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  assign total      = ({20'b0, in_total} > LIMIT) ? aubs_pkg::cnt_t'(LIMIT) : in_total;
  assign zero_total = (total == '0);

  aubs_window u_window (
    .total       (total),
    .guaranteed  (guaranteed_count),
    .floor_count (cfg.floor_count),
    .cursor      (rotate_cursor),
    .win         (win)
  );

  aubs_adapt u_adapt (
    .total  (total),
    .sample (in_sample),
    .g      (win.g),
    .pool   (win.pool),
    .cfg    (cfg),
    .avg    (average_time),
    .seen   (time_seen),
    .succ   (success_counter),
    .fail   (failure_counter),
    .res    (adapt)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.floor_count <= aubs_pkg::FLOOR_RST;
      cfg.grow_step   <= aubs_pkg::GROW_RST;
      cfg.shrink_step <= aubs_pkg::SHRINK_RST;
      cfg.success_run <= aubs_pkg::SUCC_RUN_RST;
      cfg.failure_run <= aubs_pkg::FAIL_RUN_RST;
      cfg.weight      <= aubs_pkg::WEIGHT_RST;
      cfg.target      <= aubs_pkg::TARGET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (aubs_pkg::reg_idx_t'(cfg_index))
        aubs_pkg::REG_FLOOR:    cfg.floor_count <= cfg_data[11:0];
        aubs_pkg::REG_GROW:     cfg.grow_step   <= cfg_data[7:0];
        aubs_pkg::REG_SHRINK:   cfg.shrink_step <= cfg_data[7:0];
        aubs_pkg::REG_SUCC_RUN: cfg.success_run <= cfg_data[3:0];
        aubs_pkg::REG_FAIL_RUN: cfg.failure_run <= cfg_data[3:0];
        aubs_pkg::REG_WEIGHT:   cfg.weight      <= cfg_data[8:0];
        aubs_pkg::REG_TARGET:   cfg.target      <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_total  <= s_tdata[11:0];
      in_sample <= s_tdata[31:12];
    end
  end

  // scheduler state, updated once per word with a nonzero total as it passes
  always_ff @(posedge clk) begin
    if (rst) begin
      guaranteed_count <= aubs_pkg::FLOOR_RST;
      rotate_cursor    <= '0;
      success_counter  <= '0;
      failure_counter  <= '0;
      time_seen        <= 1'b0;
      average_time     <= '0;
    end else if (advance && !zero_total) begin
      guaranteed_count <= adapt.g_next;
      rotate_cursor    <= win.cursor_next;
      success_counter  <= adapt.succ_next;
      failure_counter  <= adapt.fail_next;
      time_seen        <= adapt.seen_next;
      average_time     <= adapt.avg_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_skipped <= zero_total;
      if (zero_total) begin
        out_high   <= '0;
        out_start  <= '0;
        out_rr     <= '0;
        out_pool   <= '0;
        out_from   <= '0;
        out_to     <= '0;
        out_next_g <= guaranteed_count;
      end else begin
        out_high   <= win.high;
        out_start  <= win.start;
        out_rr     <= win.rr;
        out_pool   <= win.pool;
        out_from   <= adapt.clr_from;
        out_to     <= adapt.clr_to;
        out_next_g <= adapt.g_next;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_skipped;
  assign m_tdata  = {4'b0, out_next_g, out_to, out_from, out_pool, out_rr, out_start, out_high};

  // a word leaving the input stage always shows up at the output next cycle
  a_advance_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("result register missed a word");

  // skipped frames carry empty ranges
  a_skip_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[71:0] == '0))
    else $error("skipped frame with non-empty ranges");

  // fixed head fits in the pool, window no longer than the head
  a_window_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[11:0] <= m_tdata[47:36]) && (m_tdata[35:24] <= m_tdata[11:0])))
    else $error("window out of order");

  // a demotion range always ends at the pool size
  a_clear_shrinks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[71:60] > m_tdata[59:48])) |-> (m_tdata[71:60] == m_tdata[47:36]))
    else $error("demoted range does not end at pool");

endmodule

// ===== sv/aubs_window.sv =====
// ----------------------------------------------------------------------------
// aubs_window
// Clamps the guaranteed count and works out pool, fixed head and the
// round-robin window with its wrapping cursor.
// ----------------------------------------------------------------------------
module aubs_window (
  input  aubs_pkg::cnt_t total,
  input  aubs_pkg::cnt_t guaranteed,
  input  aubs_pkg::cnt_t floor_count,
  input  aubs_pkg::cnt_t cursor,
  output aubs_pkg::win_t win
);

  aubs_pkg::cnt_t g, pool, high, rem, rr, cur;
  logic [13:0]    g3;
  logic [12:0]    off;

  always_comb begin
    if (guaranteed < floor_count) begin
      g = floor_count;
    end else if (guaranteed > total) begin
      g = total;
    end else begin
      g = guaranteed;
    end

    g3   = {2'b00, g} + {1'b0, g, 1'b0};
    pool = (g3 < {2'b00, total}) ? g3[11:0] : total;
    high = (g < pool) ? g : pool;
    rem  = pool - high;
    rr   = (g < rem) ? g : rem;

    // cursor outside the rotating part restarts at its head
    cur = ((cursor < high) || (cursor >= pool)) ? high : cursor;
    off = {1'b0, cur - high} + {1'b0, rr};
    if (off >= {1'b0, rem}) begin
      off = off - {1'b0, rem};
    end

    win.g    = g;
    win.high = high;
    win.pool = pool;
    win.rr   = rr;
    if (rem != '0) begin
      win.start       = cur;
      win.cursor_next = high + off[11:0];
    end else begin
      win.start       = high;
      win.cursor_next = cursor;
    end
  end

endmodule

// ===== sv/aubs_adapt.sv =====
// ----------------------------------------------------------------------------
// aubs_adapt
// Moving average of the non-render time, budget test and the grow / shrink
// hysteresis on the guaranteed count.
// ----------------------------------------------------------------------------
module aubs_adapt (
  input  aubs_pkg::cnt_t total,
  input  aubs_pkg::us_t  sample,
  input  aubs_pkg::cnt_t g,
  input  aubs_pkg::cnt_t pool,
  input  aubs_pkg::cfg_t cfg,
  input  aubs_pkg::avg_t avg,
  input  logic           seen,
  input  aubs_pkg::run_t succ,
  input  aubs_pkg::run_t fail,
  output aubs_pkg::adapt_t res
);

  logic [13:0]    floor3, new_pool3;
  logic           big, neg, roomy, tight;
  aubs_pkg::wgt_t w, w_inv;
  logic [28:0]    prod_new;
  logic [36:0]    prod_old;
  logic [37:0]    acc;
  aubs_pkg::avg_t avg_upd, avg_new;
  logic [28:0]    diff;
  aubs_pkg::run_t succ_inc, fail_inc;
  logic [12:0]    g_sum, floor_shr;
  aubs_pkg::cnt_t g_shr, new_pool;

  always_comb begin
    floor3 = {2'b00, cfg.floor_count} + {1'b0, cfg.floor_count, 1'b0};
    big    = {2'b00, total} > floor3;

    // avg' = (w*sample*256 + (256-w)*avg + 128) / 256
    w        = (cfg.weight > aubs_pkg::WEIGHT_ONE) ? aubs_pkg::WEIGHT_ONE : cfg.weight;
    w_inv    = aubs_pkg::WEIGHT_ONE - w;
    prod_new = w * sample;
    prod_old = w_inv * avg;
    acc      = {1'b0, prod_new, 8'b0} + {1'b0, prod_old} + aubs_pkg::ROUND_Q8;
    avg_upd  = acc[35:8];
    avg_new  = seen ? avg_upd : aubs_pkg::SEED_Q8;

    // budget cap sits above both thresholds, only the sign matters
    diff  = {1'b0, cfg.target, 8'b0} - {1'b0, avg_new};
    neg   = diff[28];
    roomy = !neg && (diff[27:0] > aubs_pkg::ROOMY_Q8);
    tight = neg || (diff[27:0] <= aubs_pkg::TIGHT_Q8);

    succ_inc  = succ + 4'd1;
    fail_inc  = fail + 4'd1;
    g_sum     = {1'b0, g} + {5'b0, cfg.grow_step};
    floor_shr = {1'b0, cfg.floor_count} + {5'b0, cfg.shrink_step};
    g_shr     = ({1'b0, g} >= floor_shr) ? (g - {4'b0, cfg.shrink_step}) : cfg.floor_count;
    new_pool3 = {2'b00, g_shr} + {1'b0, g_shr, 1'b0};
    new_pool  = (new_pool3 < {2'b00, total}) ? new_pool3[11:0] : total;

    res.g_next    = g;
    res.avg_next  = avg;
    res.seen_next = seen;
    res.succ_next = succ;
    res.fail_next = fail;
    res.clr_from  = '0;
    res.clr_to    = '0;

    if (big) begin
      res.avg_next  = avg_new;
      res.seen_next = 1'b1;
      if (roomy) begin
        res.fail_next = '0;
        res.succ_next = succ_inc;
        if (succ_inc >= cfg.success_run) begin
          res.g_next    = (g_sum < {1'b0, total}) ? g_sum[11:0] : total;
          res.succ_next = '0;
        end
      end else if (tight) begin
        res.succ_next = '0;
        res.fail_next = fail_inc;
        if (fail_inc >= cfg.failure_run) begin
          res.g_next    = g_shr;
          res.fail_next = '0;
          if (new_pool < pool) begin
            res.clr_from = new_pool;
            res.clr_to   = pool;
          end
        end
      end
    end else begin
      res.seen_next = 1'b0;
      res.succ_next = '0;
      res.fail_next = '0;
    end
  end

endmodule

// ===== sim/adaptive_update_budget_scheduler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adaptive_update_budget_scheduler_tb
// Self-checking bench for the per-frame update budget scheduler.
// ----------------------------------------------------------------------------
// Frame words are pushed into the input stream while a behavioural plan of
// the scheduler (window clamp, wrapping cursor, moving average, budget and
// grow / shrink hysteresis) works out the result word due for each accepted
// frame. A monitor on the result stream pops the oldest plan and compares it
// field by field. Directed tests cover the corners first; random traffic
// under several register settings and idling patterns follows. Register
// writes happen only with nothing in flight.
// ----------------------------------------------------------------------------
module adaptive_update_budget_scheduler_tb;

  typedef longint unsigned u64_t;

  // index past the end of the register map; writes must be dropped
  localparam logic [2:0] REG_NONE = 3'd7;
  localparam longint BUDGET_CAP_Q8 = 5000 * 256;
  localparam int unsigned US_MAX = 20'hFFFFF;

  // time regimes for random frames, relative to the frame target
  typedef enum int {
    TIME_ANY,
    TIME_ROOMY,
    TIME_MIDDLE,
    TIME_TIGHT,
    TIME_EDGE
  } time_regime_t;

  // one expected result word
  typedef struct packed {
    logic           skipped;
    aubs_pkg::cnt_t high;
    aubs_pkg::cnt_t start;
    aubs_pkg::cnt_t rr;
    aubs_pkg::cnt_t pool;
    aubs_pkg::cnt_t clear_from;
    aubs_pkg::cnt_t clear_to;
    aubs_pkg::cnt_t next_g;
  } frame_plan_t;

  logic        clk;
  logic        rst        = 1'b1;
  logic        s_tvalid   = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata    = '0;
  logic        m_tvalid;
  logic        m_tready   = 1'b0;
  logic [87:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [19:0] cfg_data   = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int mismatch_count = 0;

  // plans for accepted frames, oldest first
  frame_plan_t frame_plans[$];

  // register shadow
  int unsigned cur_floor, cur_grow, cur_shrink, cur_succ_run, cur_fail_run;
  int unsigned cur_weight, cur_target;

  // scheduler state shadow
  int unsigned plan_g, plan_cursor, roomy_count, tight_count;
  bit          avg_seen;
  u64_t        avg_q8;

  adaptive_update_budget_scheduler i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // generous cap; a healthy run finishes far sooner
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Plan of one frame. Updates the state shadow exactly as the block does.
  // --------------------------------------------------------------------------
  function automatic frame_plan_t plan_frame(input int unsigned total,
                                             input int unsigned t_us);
    frame_plan_t p;
    int unsigned g, pool, high, rem, rr, off, new_pool;
    u64_t        w, acc;
    longint      budget;
    p = '0;
    // zero total: skipped, empty ranges, state untouched
    if (total == 0) begin
      p.skipped = 1'b1;
      p.next_g  = aubs_pkg::cnt_t'(plan_g);
      return p;
    end
    // a count below the floor is raised to it even past the total; else the total caps it
    g = plan_g;
    if (g < cur_floor) g = cur_floor;
    else if (g > total) g = total;
    pool = (3 * g < total) ? 3 * g : total;
    high = (g < pool) ? g : pool;
    rem  = pool - high;
    rr   = (g < rem) ? g : rem;
    if (rem > 0) begin
      // cursor outside the rotating part restarts at its head
      if (plan_cursor < high || plan_cursor >= pool) plan_cursor = high;
      p.start = aubs_pkg::cnt_t'(plan_cursor);
      off = plan_cursor - high + rr;
      if (off >= rem) off -= rem;
      plan_cursor = (high + off) & 12'hFFF;
    end else begin
      // nothing to rotate: window parked at the head end, cursor kept
      p.start = aubs_pkg::cnt_t'(high);
    end
    if (total > 3 * cur_floor) begin
      if (avg_seen) begin
        w   = (cur_weight > aubs_pkg::WEIGHT_ONE) ? u64_t'(aubs_pkg::WEIGHT_ONE)
                                                  : u64_t'(cur_weight);
        acc = w * (u64_t'(t_us) << 8) + (u64_t'(aubs_pkg::WEIGHT_ONE) - w) * avg_q8
              + u64_t'(aubs_pkg::ROUND_Q8);
        avg_q8 = (acc >> 8) & 64'hFFF_FFFF;
      end else begin
        // first measured frame seeds the average, sample ignored
        avg_q8 = u64_t'(aubs_pkg::SEED_Q8);
      end
      budget = longint'(cur_target) * 256 - longint'(avg_q8);
      if (budget < 0) budget = 0;
      if (budget > BUDGET_CAP_Q8) budget = BUDGET_CAP_Q8;
      if (budget > longint'(aubs_pkg::ROOMY_Q8)) begin
        tight_count = 0;
        roomy_count = (roomy_count + 1) & 4'hF;
        if (roomy_count >= cur_succ_run) begin
          g = (g + cur_grow < total) ? g + cur_grow : total;
          roomy_count = 0;
        end
      end else if (budget <= longint'(aubs_pkg::TIGHT_Q8)) begin
        roomy_count = 0;
        tight_count = (tight_count + 1) & 4'hF;
        if (tight_count >= cur_fail_run) begin
          g = (g >= cur_shrink + cur_floor) ? g - cur_shrink : cur_floor;
          new_pool = (3 * g < total) ? 3 * g : total;
          if (new_pool < pool) begin
            p.clear_from = aubs_pkg::cnt_t'(new_pool);
            p.clear_to   = aubs_pkg::cnt_t'(pool);
          end
          tight_count = 0;
        end
      end
      avg_seen = 1'b1;
    end else begin
      // small list: hysteresis restarts, average kept
      avg_seen    = 1'b0;
      roomy_count = 0;
      tight_count = 0;
    end
    plan_g   = g & 12'hFFF;
    p.high   = aubs_pkg::cnt_t'(high);
    p.rr     = aubs_pkg::cnt_t'(rr);
    p.pool   = aubs_pkg::cnt_t'(pool);
    p.next_g = aubs_pkg::cnt_t'(plan_g);
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    frame_plan_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (frame_plans.size() == 0) begin
        $error("result word with no frame outstanding");
        mismatch_count++;
      end else begin
        want = frame_plans.pop_front();
        check_field("skipped",         want.skipped,    m_tuser);
        check_field("high_count",      want.high,       m_tdata[11:0]);
        check_field("rotate_start",    want.start,      m_tdata[23:12]);
        check_field("rotate_count",    want.rr,         m_tdata[35:24]);
        check_field("pool_size",       want.pool,       m_tdata[47:36]);
        check_field("clear_from",      want.clear_from, m_tdata[59:48]);
        check_field("clear_to",        want.clear_to,   m_tdata[71:60]);
        check_field("next_guaranteed", want.next_g,     m_tdata[83:72]);
      end
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus primitives. All start and end on a falling edge.
  // --------------------------------------------------------------------------
  // Valid stays high into the next word when no gap is drawn.
  task automatic send_frame(input aubs_pkg::cnt_t total, input aubs_pkg::us_t t_us);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {t_us, total};
    do @(posedge clk); while (!s_tready);
    frame_plans.push_back(plan_frame(total, t_us));
    @(negedge clk);
  endtask

  // Stop sending and let every outstanding result drain.
  task automatic wait_plans_done();
    s_tvalid <= 1'b0;
    while (frame_plans.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [19:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      aubs_pkg::REG_FLOOR:    cur_floor    = value[11:0];
      aubs_pkg::REG_GROW:     cur_grow     = value[7:0];
      aubs_pkg::REG_SHRINK:   cur_shrink   = value[7:0];
      aubs_pkg::REG_SUCC_RUN: cur_succ_run = value[3:0];
      aubs_pkg::REG_FAIL_RUN: cur_fail_run = value[3:0];
      aubs_pkg::REG_WEIGHT:   cur_weight   = value[8:0];
      aubs_pkg::REG_TARGET:   cur_target   = value[19:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [19:0] floor_v, input logic [19:0] grow_v,
                            input logic [19:0] shrink_v, input logic [19:0] srun_v,
                            input logic [19:0] frun_v, input logic [19:0] weight_v,
                            input logic [19:0] target_v);
    wait_plans_done();
    write_reg(aubs_pkg::REG_FLOOR,    floor_v);
    write_reg(aubs_pkg::REG_GROW,     grow_v);
    write_reg(aubs_pkg::REG_SHRINK,   shrink_v);
    write_reg(aubs_pkg::REG_SUCC_RUN, srun_v);
    write_reg(aubs_pkg::REG_FAIL_RUN, frun_v);
    write_reg(aubs_pkg::REG_WEIGHT,   weight_v);
    write_reg(aubs_pkg::REG_TARGET,   target_v);
  endtask

  // random bits above the register width; the block must mask them off
  function automatic logic [19:0] with_noise(input int unsigned v, input int width);
    logic [19:0] mask;
    mask = (20'd1 << width) - 20'd1;
    return (20'($urandom) & ~mask) | (20'(v) & mask);
  endfunction

  function automatic aubs_pkg::cnt_t pick_total();
    int unsigned big_lo;
    big_lo = 3 * cur_floor + 1;
    case ($urandom_range(19))
      0, 1:    return '0;
      2, 3, 4: return aubs_pkg::cnt_t'($urandom_range(1, (big_lo > 4095) ? 4095
                                                                          : big_lo - 1));
      5, 6:    return aubs_pkg::cnt_t'($urandom);
      default: return (big_lo > 4095) ? aubs_pkg::cnt_t'($urandom)
                                      : aubs_pkg::cnt_t'($urandom_range(big_lo, 4095));
    endcase
  endfunction

  // sample steering the average into one budget band
  function automatic aubs_pkg::us_t pick_time(input time_regime_t regime);
    int t, r;
    t = int'(cur_target);
    case (regime)
      TIME_ROOMY: begin
        r = $urandom_range(1600, 20000);
        t = t - r;
      end
      TIME_MIDDLE: begin
        r = $urandom_range(550, 1450);
        t = t - r;
      end
      TIME_TIGHT: begin
        r = $urandom_range(0, 5000);
        t = t - 500 + r;
      end
      TIME_EDGE: t = $urandom_range(1) ? int'(US_MAX) : 0;
      default:   t = int'($urandom_range(0, US_MAX));
    endcase
    if (t < 0) t = 0;
    if (t > int'(US_MAX)) t = int'(US_MAX);
    return aubs_pkg::us_t'(t);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Power-up registers: skipped frame, seeding, saturated sample, small lists.
  task automatic test_reset_config();
    send_frame(12'd0,    20'hFFFFF);
    send_frame(12'd4095, 20'd0);
    send_frame(12'd4095, 20'hFFFFF);
    send_frame(12'd1,    20'd0);
    send_frame(12'd90,   20'd100);
    send_frame(12'd91,   20'd8000);
  endtask

  // Write past the register map must leave everything alone.
  task automatic test_unknown_register();
    wait_plans_done();
    write_reg(REG_NONE, 20'hFFFFF);
    send_frame(12'd4095, 20'd20000);
  endtask

  // Window corners: empty rotating part, cursor wrap, cursor out of range,
  // floor at or above the total.
  task automatic test_window_edges();
    set_config(1, 5, 15, 4, 1, 38, 16600);
    send_frame(12'd1, 20'd0);
    repeat (3) send_frame(12'd3, 20'd0);
    send_frame(12'd2, 20'd0);
    set_config(4095, 5, 15, 4, 1, 38, 16600);
    send_frame(12'd4095, 20'd0);
    send_frame(12'd100,  20'd0);
  endtask

  // Grow / shrink decisions, zero run lengths, weight saturation, target ends.
  task automatic test_budget_adaptation();
    set_config(10, 255, 255, 0, 0, 256, 20000);
    send_frame(12'd4095, 20'd0);
    send_frame(12'd4095, 20'd0);
    send_frame(12'd4095, 20'd20000);
    send_frame(12'd4095, 20'd19000);
    set_config(10, 1, 1, 15, 15, 300, 0);
    send_frame(12'd4095, 20'd0);
    send_frame(12'd4095, 20'hFFFFF);
    set_config(10, 1, 1, 15, 15, 0, 20'hFFFFF);
    send_frame(12'd4095, 20'd12345);
  endtask

  // Random frames under three idling patterns and five settings each; the
  // first two settings of every pattern are the register extremes.
  task automatic test_random_traffic(input int frames_per_setting);
    time_regime_t regime;
    int           regime_left;
    int unsigned  floor_v, target_v;
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       begin tx_idle_pct = 25; rx_idle_pct = 50; end
        1:       begin tx_idle_pct = 50; rx_idle_pct = 25; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      for (int setting = 0; setting < 5; setting++) begin
        case (setting)
          0: set_config(1, 255, 255, 0, 1, 256, 16600);
          1: set_config(4095, 0, 0, 15, 15, 511, 20'hFFFFF);
          default: begin
            floor_v = ($urandom_range(4) == 0) ? $urandom_range(1, 4095)
                                               : $urandom_range(1, 300);
            case ($urandom_range(9))
              0:       target_v = 0;
              1:       target_v = $urandom_range(0, US_MAX);
              default: target_v = $urandom_range(5000, 40000);
            endcase
            set_config(with_noise(floor_v, 12),
                       with_noise($urandom_range(255), 8),
                       with_noise($urandom_range(255), 8),
                       with_noise($urandom_range(15), 4),
                       with_noise($urandom_range(15), 4),
                       with_noise($urandom_range(511), 9),
                       20'(target_v));
          end
        endcase
        regime_left = 0;
        regime = TIME_ANY;
        for (int n = 0; n < frames_per_setting; n++) begin
          // hold one band for a stretch so the average settles into it
          if (regime_left == 0) begin
            regime      = time_regime_t'($urandom_range(4));
            regime_left = $urandom_range(8, 30);
          end
          regime_left--;
          // now and then hold off until every result is back
          if ($urandom_range(99) == 0) wait_plans_done();
          send_frame(pick_total(), pick_time(regime));
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    cur_floor    = aubs_pkg::FLOOR_RST;
    cur_grow     = aubs_pkg::GROW_RST;
    cur_shrink   = aubs_pkg::SHRINK_RST;
    cur_succ_run = aubs_pkg::SUCC_RUN_RST;
    cur_fail_run = aubs_pkg::FAIL_RUN_RST;
    cur_weight   = aubs_pkg::WEIGHT_RST;
    cur_target   = aubs_pkg::TARGET_RST;
    plan_g       = aubs_pkg::FLOOR_RST;
    plan_cursor  = 0;
    roomy_count  = 0;
    tight_count  = 0;
    avg_seen     = 1'b0;
    avg_q8       = 0;
    tx_idle_pct  = 25;
    rx_idle_pct  = 50;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_config();
    test_unknown_register();
    test_window_edges();
    test_budget_adaptation();
    test_random_traffic(117);

    wait_plans_done();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/aubs_pkg.sv
sv/aubs_window.sv
sv/aubs_adapt.sv
sv/adaptive_update_budget_scheduler.sv
sim/adaptive_update_budget_scheduler_tb.sv
